@@ rtl/scw_pkg.sv @@
// ----------------------------------------------------------------------------
// scw_pkg
// Shared types and constants of the sector chain walker.
// ----------------------------------------------------------------------------
package scw_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 64;

  localparam int unsigned FUNC_W   = 1;
  localparam int unsigned IDX_W    = 6;
  localparam int unsigned LINK_W   = 32;
  localparam int unsigned SECTOR_W = 6;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned LEN_W    = 7;

  localparam int unsigned IN_TDATA_W  = 72;
  localparam int unsigned OUT_TDATA_W = 8;

  localparam logic [FUNC_W-1:0] FUNC_WRITE = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_WALK  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_START = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BEYOND    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_TOO_LONG  = 2'd3;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  addr;
    logic [LINK_W-1:0] data;
  } wr_req_t;

endpackage

@@ rtl/scw_link_ram.sv @@
// ----------------------------------------------------------------------------
// scw_link_ram
// Link table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module scw_link_ram
  import scw_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
  localparam int unsigned AW = $clog2(TABLE_DEPTH)
) (
  input  logic              clk_i,
  input  wr_req_t           wr_i,
  input  logic [AW-1:0]     rd_addr_i,
  output logic [LINK_W-1:0] rd_data_o
);

  logic [LINK_W-1:0] mem_q [TABLE_DEPTH];
  logic [LINK_W-1:0] rd_data_q;

  // drop writes beyond the table
  always_ff @(posedge clk_i) begin
    if (wr_i.en && ({26'b0, wr_i.addr} < 32'(TABLE_DEPTH))) begin
      mem_q[wr_i.addr[AW-1:0]] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ rtl/sector_chain_walker_core.sv @@
// ----------------------------------------------------------------------------
// sector_chain_walker_core
// Walks sector chains through a table of signed next-sector links.
//
//   channel  | direction | tdata                                   | tuser / tlast
//   s_axis   | in        | entry_index, entry_value, start_sector  | tuser: func
//   m_axis   | out       | sector_id                               | tuser: status, tlast: last
//   cfg      | in        | entries_in_use                          | -
//
// A write transaction is written to the table when accepted. A walk handles
// each emitted sector as a table read, then an evaluate, set by the single
// table read port; up to TABLE_DEPTH sectors per walk. A stalled output holds
// the evaluation step. Reset clears control state and entries_in_use; the
// table is undefined until written. s_axis_tready_o is low from the start of
// a walk until its final result is loaded.
// ----------------------------------------------------------------------------
module sector_chain_walker_core
  import scw_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // [5:0] entry_index, [37:6] entry_value, [69:38] start_sector, [71:70] zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // [0] func
  input  logic [FUNC_W-1:0]      s_axis_tuser_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // [5:0] sector_id, [7:6] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  // [1:0] status
  output logic [STATUS_W-1:0]    m_axis_tuser_o,
  output logic                   m_axis_tlast_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [LEN_W-1:0]       cfg_data_i
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD   = 4'b0010,
    S_EVAL = 4'b0100,
    S_BAD  = 4'b1000
  } state_e;

  state_e               state_q, state_d;
  logic [LEN_W-1:0]     entries_q;
  logic [AW-1:0]        cur_q, cur_d;
  logic [CW-1:0]        count_q, count_d;
  logic                 out_valid_q, out_valid_d;
  logic [SECTOR_W-1:0]  out_sector_q, out_sector_d;
  logic                 out_last_q, out_last_d;
  logic [STATUS_W-1:0]  out_status_q, out_status_d;

  logic [LEN_W-1:0]     len;
  logic                 in_acc;
  logic [IDX_W-1:0]     in_idx;
  logic [LINK_W-1:0]    in_value;
  logic [LINK_W-1:0]    in_start;
  logic [LINK_W-1:0]    link;
  logic                 can_load;
  logic                 link_end;
  logic                 link_beyond;
  logic                 too_long;
  wr_req_t              wr;

  assign len = (32'(entries_q) > 32'(TABLE_DEPTH)) ? LEN_W'(TABLE_DEPTH) : entries_q;

  assign in_idx   = s_axis_tdata_i[IDX_W-1:0];
  assign in_value = s_axis_tdata_i[IDX_W+LINK_W-1:IDX_W];
  assign in_start = s_axis_tdata_i[IDX_W+2*LINK_W-1:IDX_W+LINK_W];

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;

  assign wr.en   = in_acc && (s_axis_tuser_i == FUNC_WRITE);
  assign wr.addr = in_idx;
  assign wr.data = in_value;

  scw_link_ram #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk_i    (clk_i),
    .wr_i     (wr),
    .rd_addr_i(cur_q),
    .rd_data_o(link)
  );

  assign can_load    = !out_valid_q || m_axis_tready_i;
  assign link_end    = link[LINK_W-1];
  assign link_beyond = !link_end && (link >= 32'(len));
  assign too_long    = (LEN_W'(count_q) + LEN_W'(1)) >= len;

  always_comb begin
    state_d      = state_q;
    cur_d        = cur_q;
    count_d      = count_q;
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    out_sector_d = out_sector_q;
    out_last_d   = out_last_q;
    out_status_d = out_status_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && (s_axis_tuser_i == FUNC_WALK)) begin
          count_d = '0;
          cur_d   = in_start[AW-1:0];
          if (in_start[LINK_W-1] || (in_start >= 32'(len))) begin
            state_d = S_BAD;
          end else begin
            state_d = S_RD;
          end
        end
      end
      S_RD: begin
        state_d = S_EVAL;
      end
      S_EVAL: begin
        if (can_load) begin
          out_valid_d  = 1'b1;
          out_sector_d = SECTOR_W'(cur_q);
          if (link_end || link_beyond || too_long) begin
            out_last_d = 1'b1;
            if (link_end) begin
              out_status_d = ST_OK;
            end else if (link_beyond) begin
              out_status_d = ST_BEYOND;
            end else begin
              out_status_d = ST_TOO_LONG;
            end
            state_d = S_IDLE;
          end else begin
            out_last_d   = 1'b0;
            out_status_d = ST_OK;
            cur_d        = link[AW-1:0];
            count_d      = count_q + CW'(1);
            state_d      = S_RD;
          end
        end
      end
      S_BAD: begin
        if (can_load) begin
          out_valid_d  = 1'b1;
          out_sector_d = '0;
          out_last_d   = 1'b1;
          out_status_d = ST_BAD_START;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      entries_q   <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        entries_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q        <= cur_d;
    out_sector_q <= out_sector_d;
    out_last_q   <= out_last_d;
    out_status_q <= out_status_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_TDATA_W'(out_sector_q);
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

@@ bench/sector_chain_walker_checker.sv @@
// ----------------------------------------------------------------------------
// sector_chain_walker_checker
// Watches the input, configuration and result channels of the sector chain
// walker. Keeps its own copy of the link table and the table length, expands
// each accepted walk transaction into the sector sequence it must produce,
// and compares every accepted result field by field against the oldest
// outstanding sector. Hands the mismatch count and the number of outstanding
// sectors to the testbench top.
// ----------------------------------------------------------------------------
module sector_chain_walker_checker
  import scw_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_valid_i,
  input  logic                   s_ready_i,
  input  logic [IN_TDATA_W-1:0]  s_tdata_i,
  input  logic [FUNC_W-1:0]      s_tuser_i,
  input  logic                   m_valid_i,
  input  logic                   m_ready_i,
  input  logic [OUT_TDATA_W-1:0] m_tdata_i,
  input  logic [STATUS_W-1:0]    m_tuser_i,
  input  logic                   m_tlast_i,
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_i,
  input  logic [LEN_W-1:0]       cfg_data_i,
  output int                     fail_count_o,
  output int                     pending_o
);

  typedef struct packed {
    logic [SECTOR_W-1:0] sector;
    logic                last;
    logic [STATUS_W-1:0] status;
  } chain_step_t;

  logic [LINK_W-1:0] link_mirror [TABLE_DEPTH_DEF];
  logic [LEN_W-1:0]  len_mirror = '0;
  chain_step_t       chain_steps_q [$];
  chain_step_t       want;
  int                errors = 0;

  assign fail_count_o = errors;

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  task automatic append_step(input chain_step_t item);
    chain_steps_q = {chain_steps_q, item};
  endtask

  task automatic walk_chain(input logic [LINK_W-1:0] start);
    int unsigned       span;
    int unsigned       emitted;
    logic [LINK_W-1:0] cur;
    logic [LINK_W-1:0] nxt;
    chain_step_t       step;
    span = (len_mirror > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : len_mirror;
    if (start[LINK_W-1] || start >= span) begin
      step.sector = '0;
      step.last   = 1'b1;
      step.status = ST_BAD_START;
      append_step(step);
      return;
    end
    cur     = start;
    emitted = 0;
    step.last = 1'b0;
    while (!step.last) begin
      nxt         = link_mirror[cur[IDX_W-1:0]];
      step.sector = cur[SECTOR_W-1:0];
      step.last   = 1'b1;
      if (nxt[LINK_W-1]) begin
        step.status = ST_OK;
      end else if (nxt >= span) begin
        step.status = ST_BEYOND;
      end else if (emitted + 1 >= span) begin
        step.status = ST_TOO_LONG;
      end else begin
        step.last   = 1'b0;
        step.status = ST_OK;
        cur         = nxt;
      end
      append_step(step);
      emitted++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_valid_i && m_ready_i) begin
        if (chain_steps_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result sector %0d status %0d last %0b",
                                    m_tdata_i[SECTOR_W-1:0], m_tuser_i, m_tlast_i));
        end else begin
          want = chain_steps_q.pop_front();
          if (m_tdata_i[SECTOR_W-1:0] !== want.sector) begin
            report_mismatch($sformatf("sector_id got %0d want %0d",
                                      m_tdata_i[SECTOR_W-1:0], want.sector));
          end
          if (m_tlast_i !== want.last) begin
            report_mismatch($sformatf("last got %0b want %0b at sector %0d",
                                      m_tlast_i, want.last, want.sector));
          end
          if (m_tuser_i !== want.status) begin
            report_mismatch($sformatf("status got %0d want %0d at sector %0d",
                                      m_tuser_i, want.status, want.sector));
          end
        end
      end
      if (s_valid_i && s_ready_i) begin
        if (s_tuser_i == FUNC_WRITE) begin
          link_mirror[s_tdata_i[IDX_W-1:0]] = s_tdata_i[IDX_W +: LINK_W];
        end else begin
          walk_chain(s_tdata_i[IDX_W+LINK_W +: LINK_W]);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        len_mirror = cfg_data_i;
      end
    end
    pending_o <= chain_steps_q.size();
  end

endmodule

@@ bench/sector_chain_walker_core_tb.sv @@
// ----------------------------------------------------------------------------
// sector_chain_walker_core_tb
// Regression for the sector chain walker core. Fills the link table, runs a
// short directed set of chains (normal end, bad start, link beyond table,
// cyclic chain), then random writes, walks and freshly built chains under
// several table lengths and three idle profiles, including one long output
// hold-off that backs up the input. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module sector_chain_walker_core_tb;
  import scw_pkg::*;

  localparam int unsigned LIMIT         = 2000000;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned DRAIN_CYCLES  = 20;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   s_valid = 1'b0;
  logic                   s_ready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic [FUNC_W-1:0]      s_tuser = '0;
  logic                   m_valid;
  logic                   m_ready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [STATUS_W-1:0]    m_tuser;
  logic                   m_tlast;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [LEN_W-1:0]       cfg_data = '0;

  int          errors;
  int          pending;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned cur_len = 0;
  int unsigned items_sent = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_left;
  bit          hold_req = 1'b0;

  always #10 clk = ~clk;

  sector_chain_walker_core dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_data_i      (cfg_data)
  );

  sector_chain_walker_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_valid_i    (s_valid),
    .s_ready_i    (s_ready),
    .s_tdata_i    (s_tdata),
    .s_tuser_i    (s_tuser),
    .m_valid_i    (m_valid),
    .m_ready_i    (m_ready),
    .m_tdata_i    (m_tdata),
    .m_tuser_i    (m_tuser),
    .m_tlast_i    (m_tlast),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .fail_count_o (errors),
    .pending_o    (pending)
  );

  initial begin
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // hold off for a long stretch on request, else idle at random
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_ready <= 1'b0;
        for (hold_left = HOLD_CYCLES; hold_left > 1; hold_left--) @(posedge clk);
      end else begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_item(input logic [FUNC_W-1:0] func, input logic [IDX_W-1:0] idx,
                           input logic [LINK_W-1:0] value, input logic [LINK_W-1:0] start);
    while ($urandom_range(99) < send_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk);
    end
    s_valid <= 1'b1;
    s_tdata <= {{(IN_TDATA_W-IDX_W-2*LINK_W){1'b0}}, start, value, idx};
    s_tuser <= func;
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_write(input logic [IDX_W-1:0] idx, input logic [LINK_W-1:0] value);
    send_item(FUNC_WRITE, idx, value, $urandom());
  endtask

  task automatic send_walk(input logic [LINK_W-1:0] start);
    send_item(FUNC_WALK, IDX_W'($urandom()), $urandom(), start);
  endtask

  task automatic settle();
    s_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_table_len(input logic [LEN_W-1:0] len);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= len;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_len = (len > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : len;
  endtask

  function automatic logic [LINK_W-1:0] pick_link(input bit allow_valid);
    logic [LINK_W-1:0] v;
    int unsigned       kind;
    kind = $urandom_range(3);
    if (allow_valid && cur_len > 0 && kind >= 2) begin
      v = $urandom_range(cur_len - 1, 0);
    end else if (kind[0]) begin
      v = {1'b1, 31'($urandom())};
    end else if (cur_len < TABLE_DEPTH_DEF && $urandom_range(1) == 1) begin
      v = $urandom_range(TABLE_DEPTH_DEF - 1, cur_len);
    end else begin
      v = {1'b0, 31'($urandom())};
      if (v < cur_len) v = cur_len;
    end
    return v;
  endfunction

  function automatic logic [LINK_W-1:0] pick_start();
    int unsigned kind;
    kind = $urandom_range(9);
    if (kind < 7 && cur_len > 0) return $urandom_range(cur_len - 1, 0);
    if (kind < 8) return {1'b1, 31'($urandom())};
    if (kind < 9) return $urandom_range(127, cur_len);
    return {1'b0, 31'($urandom())};
  endfunction

  task automatic run_random(input int unsigned n);
    int unsigned      goal;
    int unsigned      k;
    int unsigned      pick;
    logic [IDX_W-1:0] hops [8];
    goal = items_sent + n;
    while (items_sent < goal) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        send_write(IDX_W'($urandom()), pick_link(1'b1));
      end else if (pick < 65) begin
        send_walk(pick_start());
      end else if (pick < 90 && cur_len > 0) begin
        // build a chain, terminate it (end, beyond or cycle), then walk it
        k = $urandom_range((cur_len < 8) ? cur_len : 8, 1);
        for (int i = 0; i < k; i++) hops[i] = IDX_W'($urandom_range(cur_len - 1, 0));
        for (int i = 0; i + 1 < k; i++) send_write(hops[i], LINK_W'(hops[i+1]));
        if ($urandom_range(2) == 0) begin
          send_write(hops[k-1], LINK_W'(hops[0]));
        end else begin
          send_write(hops[k-1], pick_link(1'b0));
        end
        send_walk(LINK_W'(hops[0]));
      end else begin
        send_walk($urandom());
      end
    end
  endtask

  task automatic run_phase(input int unsigned s_idle, input int unsigned r_idle,
                           input bit squeeze, input logic [LEN_W-1:0] len0,
                           input logic [LEN_W-1:0] len1, input logic [LEN_W-1:0] len2,
                           input logic [LEN_W-1:0] len3);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    set_table_len(len0);
    if (squeeze) hold_req = 1'b1;
    run_random(24);
    set_table_len(len1);
    run_random(24);
    set_table_len(len2);
    run_random(24);
    set_table_len(len3);
    run_random(24);
  endtask

  initial begin
    send_idle_pct = 27;
    recv_idle_pct = 86;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < TABLE_DEPTH_DEF; i++) send_write(IDX_W'(i), pick_link(1'b1));

    send_walk(32'd0);
    send_walk(32'h8000_0000);

    set_table_len(7'd8);
    send_write(6'd0, 32'd1);
    send_write(6'd1, 32'd2);
    send_write(6'd2, 32'hFFFF_FFFF);
    send_walk(32'd0);
    send_write(6'd3, 32'd8);
    send_walk(32'd3);
    send_write(6'd4, 32'h7FFF_FFFF);
    send_walk(32'd4);
    send_write(6'd5, 32'd6);
    send_write(6'd6, 32'd5);
    send_walk(32'd5);
    send_write(6'd7, 32'h8000_0000);
    send_walk(32'd7);
    send_walk(32'd8);
    send_walk(32'h7FFF_FFFF);
    send_walk(32'hFFFF_FFFF);

    set_table_len(7'd64);
    send_write(6'd63, 32'd0);
    send_walk(32'd63);
    send_walk(32'd64);

    run_phase(27, 86, 1'b0, 7'd1, 7'd64, LEN_W'($urandom_range(63, 2)), 7'd0);
    run_phase(86, 27, 1'b0, 7'd127, 7'd2, LEN_W'($urandom_range(126, 65)),
              LEN_W'($urandom_range(64, 0)));
    run_phase(0, 0, 1'b1, 7'd64, LEN_W'($urandom_range(64, 1)), 7'd33, 7'd1);

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
